// File: rtl/fpba_pkg.sv
`timescale 1ns / 1ps

package fpba_pkg;

   // default sizing of the free-space table
   localparam int BLOCKS_DEF    = 16;
   localparam int SIZE_BITS_DEF = 16;

   // fixed field widths
   localparam int INDEX_W  = 4;
   localparam int AMOUNT_W = 16;
   localparam int COUNT_W  = 5;
   localparam int POLICY_W = 2;
   localparam int CSR_W    = 5;
   localparam int TDATA_W  = 24;

   localparam logic [COUNT_W-1:0] BCOUNT_RESET = 5'd16;

   typedef enum logic [POLICY_W-1:0] {
      POL_FIRST = 2'd0,
      POL_BEST  = 2'd1,
      POL_NEXT  = 2'd2,
      POL_WORST = 2'd3
   } policy_type;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_ALLOC = 1'b1
   } req_kind_type;

   typedef enum logic {
      CSR_POLICY = 1'b0,
      CSR_COUNT  = 1'b1
   } csr_index_type;

endpackage

// File: rtl/fpba_ram.sv
`timescale 1ns / 1ps

module fpba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/fit_policy_block_allocator.sv
`timescale 1ns / 1ps

// fit-policy block allocator
//
// req channel: one transfer per item. req_tuser is the kind (0 load, 1 allocate).
// a load writes one table entry's free size and gives no response; an allocate
// asks for req_tdata amount and gives exactly one transfer on the rsp channel.
// rsp_tuser is the grant flag; rsp_tdata carries the chosen block and the space
// left in it (both zero when not granted).
// csr port: csr_we with csr_addr 0 writes the fit policy (0 first, 1 best,
// 2 next, 3 worst), csr_addr 1 writes the number of blocks in use. write only
// while no allocate is in flight.
// an allocate examines at most the block count of table entries: the table sits
// in one memory with a registered read port, and the scan reads one entry a cycle.
// first and next fit stop at the first entry that fits.
// reset clears all free sizes to zero (per-entry valid bits, no clearing pass),
// the next-fit start point, and the registers to first fit with 16 blocks.
// the response sits in an output register; a stalled receiver holds it there,
// and only the next allocate waits at its final cycle until the register frees.

module fit_policy_block_allocator #(
   parameter int BLOCKS    = fpba_pkg::BLOCKS_DEF,
   parameter int SIZE_BITS = fpba_pkg::SIZE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [fpba_pkg::TDATA_W-1:0] req_tdata,  // load_index[3:0], amount[19:4]
   input  logic        req_tuser,                   // req_type
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [fpba_pkg::TDATA_W-1:0] rsp_tdata,  // chosen_block[3:0], space_left[19:4]
   output logic        rsp_tuser,                   // granted
   // configuration
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [fpba_pkg::CSR_W-1:0] csr_wdata
);

   import fpba_pkg::*;

   localparam int IDX_W  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int CNT_W  = $clog2(BLOCKS + 1);
   // requests are compared at full width even for narrow table entries
   localparam int NEED_W = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   // request fields
   logic [INDEX_W-1:0]  req_index;
   logic [AMOUNT_W-1:0] req_amount;
   assign req_index  = req_tdata[INDEX_W-1:0];
   assign req_amount = req_tdata[INDEX_W+AMOUNT_W-1:INDEX_W];

   state_type              state_ff, state_in;
   policy_type             policy_ff, policy_in;
   logic [COUNT_W-1:0]     bcount_ff, bcount_in;
   logic [INDEX_W-1:0]     next_start_ff, next_start_in;
   logic [BLOCKS-1:0]      valid_ff, valid_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [NEED_W-1:0]      need_ff, need_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [IDX_W-1:0]       chk_pos_ff, chk_pos_in;
   logic [CNT_W-1:0]       chk_num_ff, chk_num_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       pick_ff, pick_in;
   logic [SIZE_BITS-1:0]   pick_val_ff, pick_val_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_granted_ff, rsp_granted_in;
   logic [INDEX_W-1:0]     rsp_block_ff, rsp_block_in;
   logic [AMOUNT_W-1:0]    rsp_space_ff, rsp_space_in;

   // table memory controls
   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   logic [SIZE_BITS-1:0]   ram_wdata;
   logic [IDX_W-1:0]       ram_raddr;
   logic [SIZE_BITS-1:0]   ram_rdata;

   fpba_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (BLOCKS),
      .AW    (IDX_W)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // helpers
   logic                 req_xfer;
   logic                 out_free;
   logic [CNT_W-1:0]     eff_count;
   logic [IDX_W-1:0]     start_pos;
   logic [IDX_W-1:0]     nxt_pos;
   logic [SIZE_BITS-1:0] chk_data;
   logic                 fits;
   logic                 better;
   logic                 last_chk;
   logic                 stop;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // block count saturates at the table depth
   assign eff_count = (32'(bcount_ff) > BLOCKS) ? CNT_W'(BLOCKS) : CNT_W'(bcount_ff);

   // next fit resumes at the last chosen entry when still in range
   always_comb begin
      start_pos = '0;
      if (policy_ff == POL_NEXT && 32'(next_start_ff) < 32'(eff_count)) begin
         start_pos = IDX_W'(32'(next_start_ff));
      end
   end

   // scan walks with wraparound inside the entries in use
   assign nxt_pos  = (32'(chk_pos_ff) + 1 == 32'(cnt_ff)) ? '0 : chk_pos_ff + 1'b1;

   // entries never loaded read as zero
   assign chk_data = rd_vld_ff ? ram_rdata : '0;
   assign fits     = (NEED_W'(chk_data) >= need_ff);
   assign better   = !found_ff
                     || (policy_ff == POL_BEST  && chk_data < pick_val_ff)
                     || (policy_ff == POL_WORST && chk_data > pick_val_ff);
   assign last_chk = (32'(chk_num_ff) + 1 == 32'(cnt_ff));
   assign stop     = last_chk
                     || (fits && (policy_ff == POL_FIRST || policy_ff == POL_NEXT));

   always_comb begin
      state_in       = state_ff;
      policy_in      = policy_ff;
      bcount_in      = bcount_ff;
      next_start_in  = next_start_ff;
      valid_in       = valid_ff;
      need_in        = need_ff;
      cnt_in         = cnt_ff;
      chk_pos_in     = chk_pos_ff;
      chk_num_in     = chk_num_ff;
      found_in       = found_ff;
      pick_in        = pick_ff;
      pick_val_in    = pick_val_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_granted_in = rsp_granted_ff;
      rsp_block_in   = rsp_block_ff;
      rsp_space_in   = rsp_space_ff;
      ram_we         = 1'b0;
      ram_waddr      = IDX_W'(32'(req_index));
      ram_wdata      = SIZE_BITS'(req_amount);
      ram_raddr      = nxt_pos;

      // register writes
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_POLICY: policy_in = policy_type'(csr_wdata[POLICY_W-1:0]);
            CSR_COUNT:  bcount_in = csr_wdata[COUNT_W-1:0];
            default:    ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            ram_raddr = start_pos;
            if (req_xfer) begin
               if (req_kind_type'(req_tuser) == REQ_LOAD) begin
                  // loads beyond the table are dropped
                  if (32'(req_index) < BLOCKS) begin
                     ram_we                                = 1'b1;
                     valid_in[IDX_W'(32'(req_index))]      = 1'b1;
                  end
               end else begin
                  need_in    = NEED_W'(req_amount);
                  cnt_in     = eff_count;
                  chk_pos_in = start_pos;
                  chk_num_in = '0;
                  found_in   = 1'b0;
                  // nothing in use: straight to a not-granted response
                  state_in   = (eff_count == '0) ? S_DONE : S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (fits && better) begin
               found_in    = 1'b1;
               pick_in     = chk_pos_ff;
               pick_val_in = chk_data;
            end
            if (stop) begin
               state_in = S_DONE;
            end else begin
               chk_pos_in = nxt_pos;
               chk_num_in = chk_num_ff + 1'b1;
            end
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = found_ff;
               rsp_block_in   = '0;
               rsp_space_in   = '0;
               if (found_ff) begin
                  // charge the chosen entry
                  ram_we         = 1'b1;
                  ram_waddr      = pick_ff;
                  ram_wdata      = pick_val_ff - SIZE_BITS'(need_ff);
                  next_start_in  = INDEX_W'(pick_ff);
                  rsp_block_in   = INDEX_W'(pick_ff);
                  rsp_space_in   = AMOUNT_W'(pick_val_ff - SIZE_BITS'(need_ff));
               end
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      rd_vld_in = valid_ff[ram_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         policy_ff     <= POL_FIRST;
         bcount_ff     <= BCOUNT_RESET;
         next_start_ff <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         policy_ff     <= policy_in;
         bcount_ff     <= bcount_in;
         next_start_ff <= next_start_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         found_ff      <= found_in;
      end
      // datapath registers
      rd_vld_ff      <= rd_vld_in;
      need_ff        <= need_in;
      cnt_ff         <= cnt_in;
      chk_pos_ff     <= chk_pos_in;
      chk_num_ff     <= chk_num_in;
      pick_ff        <= pick_in;
      pick_val_ff    <= pick_val_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_block_ff   <= rsp_block_in;
      rsp_space_ff   <= rsp_space_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_granted_ff;
   assign rsp_tdata  = {(TDATA_W - INDEX_W - AMOUNT_W)'(0), rsp_space_ff, rsp_block_ff};

endmodule
